// ===== design/plist_pkg.sv =====
// Shared types and constants for the positional list engine.
package plist_pkg;

    // List capacity and the widths that follow from it
    localparam int CAPACITY = 64;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int PW       = 7;
    localparam int VW       = 8;
    localparam int PCW      = ((CW > PW) ? CW : PW) + 1;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2,
        OP_FIND   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        op_t           operation;
        logic [PW-1:0] position;
        logic [VW-1:0] value;
    } req_t;

    typedef struct packed {
        status_t       status;
        logic [VW-1:0] data_out;
        logic [PW-1:0] found_position;
        logic [PW-1:0] length;
    } res_t;

endpackage

// ===== design/plist_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
module plist_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ===== design/plist_ctrl.sv =====
// Sequencer that walks the list store one entry per cycle for each operation.
module plist_ctrl
    import plist_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          req_valid,
    input  req_t          req,
    output logic          req_ready,
    output logic          res_valid,
    output res_t          res,
    input  logic          res_take,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic [VW-1:0] mem_wdata,
    output logic [AW-1:0] mem_raddr,
    input  logic [VW-1:0] mem_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT_UP,
        S_PLACE,
        S_FETCH,
        S_SHIFT_DOWN,
        S_SCAN,
        S_RESULT
    } state_t;

    state_t        state_reg, state_next;
    req_t          req_reg, req_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] idx_reg, idx_next;
    status_t       status_reg, status_next;
    logic [VW-1:0] data_reg, data_next;
    logic [PW-1:0] found_reg, found_next;

    logic [PCW-1:0] pos_ext, cnt_ext, pos_m1_ext, cnt_m1_ext, cnt_p1_ext, fnd_ext;
    logic [AW-1:0]  pos_a, pos_m1, cnt_m1;
    logic [AW-1:0]  idx_inc, idx_dec, idx_lim;
    logic           idx_hit;

    // Position and count arithmetic, widened so the compares never wrap
    assign pos_ext    = PCW'(req_reg.position);
    assign cnt_ext    = PCW'(cnt_reg);
    assign pos_m1_ext = pos_ext - PCW'(1);
    assign cnt_m1_ext = cnt_ext - PCW'(1);
    assign cnt_p1_ext = cnt_ext + PCW'(1);
    assign pos_a      = pos_ext[AW-1:0];
    assign pos_m1     = pos_m1_ext[AW-1:0];
    assign cnt_m1     = cnt_m1_ext[AW-1:0];

    // Shared index unit: step up, step down, compare against the walk limit
    assign idx_inc = idx_reg + AW'(1);
    assign idx_dec = idx_reg - AW'(1);
    assign idx_lim = (state_reg == S_SHIFT_UP) ? pos_m1 : cnt_m1;
    assign idx_hit = (idx_reg == idx_lim);
    assign fnd_ext = PCW'(idx_reg) + PCW'(1);

    // Next-state and store access logic
    always_comb begin
        state_next  = state_reg;
        req_next    = req_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        data_next   = data_reg;
        found_next  = found_reg;
        mem_we      = 1'b0;
        mem_waddr   = idx_inc;
        mem_wdata   = mem_rdata;
        mem_raddr   = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    req_next   = req;
                    state_next = S_DECODE;
                end
            end

            S_DECODE: begin
                status_next = ST_OK;
                data_next   = '0;
                found_next  = '0;
                unique case (req_reg.operation)
                    OP_INSERT: begin
                        if (pos_ext == '0 || pos_ext > cnt_p1_ext) begin
                            status_next = ST_BAD_POS;
                            state_next  = S_RESULT;
                        end else if (cnt_ext == PCW'(CAPACITY)) begin
                            status_next = ST_FULL;
                            state_next  = S_RESULT;
                        end else if (pos_ext == cnt_p1_ext) begin
                            state_next = S_PLACE;
                        end else begin
                            mem_raddr  = cnt_m1;
                            idx_next   = cnt_m1;
                            state_next = S_SHIFT_UP;
                        end
                    end
                    OP_DELETE, OP_READ: begin
                        if (pos_ext == '0 || pos_ext > cnt_ext) begin
                            status_next = ST_BAD_POS;
                            state_next  = S_RESULT;
                        end else begin
                            mem_raddr  = pos_m1;
                            state_next = S_FETCH;
                        end
                    end
                    OP_FIND: begin
                        if (cnt_reg == '0) begin
                            status_next = ST_NOT_FOUND;
                            state_next  = S_RESULT;
                        end else begin
                            mem_raddr  = '0;
                            idx_next   = '0;
                            state_next = S_SCAN;
                        end
                    end
                    default: state_next = S_RESULT;
                endcase
            end

            // Move the entry just read one slot up, walking toward the insert point
            S_SHIFT_UP: begin
                mem_we    = 1'b1;
                mem_waddr = idx_inc;
                mem_wdata = mem_rdata;
                if (idx_hit) begin
                    state_next = S_PLACE;
                end else begin
                    idx_next  = idx_dec;
                    mem_raddr = idx_dec;
                end
            end

            // Drop the new value into the opened slot
            S_PLACE: begin
                mem_we     = 1'b1;
                mem_waddr  = pos_m1;
                mem_wdata  = req_reg.value;
                cnt_next   = cnt_reg + CW'(1);
                state_next = S_RESULT;
            end

            S_FETCH: begin
                data_next = mem_rdata;
                if (req_reg.operation == OP_READ) begin
                    state_next = S_RESULT;
                end else if (pos_ext == cnt_ext) begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_RESULT;
                end else begin
                    idx_next   = pos_a;
                    mem_raddr  = pos_a;
                    state_next = S_SHIFT_DOWN;
                end
            end

            // Move the entry just read one slot down to close the gap
            S_SHIFT_DOWN: begin
                mem_we    = 1'b1;
                mem_waddr = idx_dec;
                mem_wdata = mem_rdata;
                if (idx_hit) begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_RESULT;
                end else begin
                    idx_next  = idx_inc;
                    mem_raddr = idx_inc;
                end
            end

            // Compare each entry in turn; stop at the first match
            S_SCAN: begin
                if (mem_rdata == req_reg.value) begin
                    found_next = fnd_ext[PW-1:0];
                    state_next = S_RESULT;
                end else if (idx_hit) begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_RESULT;
                end else begin
                    idx_next  = idx_inc;
                    mem_raddr = idx_inc;
                end
            end

            S_RESULT: begin
                if (res_take) begin
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // Hold state, count and result fields
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        req_reg    <= req_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        data_reg   <= data_next;
        found_reg  <= found_next;
    end

    assign req_ready          = (state_reg == S_IDLE);
    assign res_valid          = (state_reg == S_RESULT);
    assign res.status         = status_reg;
    assign res.data_out       = data_reg;
    assign res.found_position = found_reg;
    assign res.length         = cnt_ext[PW-1:0];

endmodule

// ===== design/positional_list_engine.sv =====
// Top level of the positional list engine: stream ports, store and output register.
//
// Usage: each item on the s_ channel carries one operation (insert, delete,
// read, find) on an ordered list of up to CAPACITY bytes held in an on-chip
// RAM. Each item yields exactly one result item on the m_ channel with a
// status, the byte removed or read, the position found and the new length.
//
// Timing: the block takes one item at a time; s_tready is high only while
// the sequencer is idle. The sequencer walks the RAM one entry per cycle
// through its single registered read port: an insert shifts the entries
// from the position up one slot and then places the value (appending
// places it directly), a delete fetches the entry and shifts the entries
// above it down, a read fetches the entry, a find scans from the first
// entry to the first match or the end, and a rejected operation goes
// straight to its result.
// Reset clears the length to zero; the RAM needs no clearing pass, as only
// slots below the length are ever read. When the receiver stalls, the
// output register holds the result and the block still accepts and works
// one further item, which then waits until the register frees up.
module positional_list_engine
    import plist_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // operation[1:0], position[8:2], value[16:9], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // status[1:0], data_out[9:2], found_position[16:10], length[23:17]
);

    req_t          req;
    res_t          res;
    logic          res_valid, res_take;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [VW-1:0] mem_wdata, mem_rdata;
    logic          m_valid_reg;
    logic [23:0]   m_data_reg;

    // Unpack the input item
    assign req.operation = op_t'(s_tdata[1:0]);
    assign req.position  = s_tdata[8:2];
    assign req.value     = s_tdata[16:9];

    plist_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req       (req),
        .req_ready (s_tready),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    plist_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Load the output register when it is empty or being drained
    assign res_take = res_valid && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_take) begin
            m_data_reg <= {res.length, res.found_position, res.data_out, res.status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
